// ===== design/crc16_checked_frame_receiver_macros.svh =====
// Assertion macros used by the frame receiver checker.
`ifndef CRC16_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define CRC16_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Check a same-cycle implication on clk_i, off during reset.
`define CFR_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check a next-cycle implication on clk_i, off during reset.
`define CFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cfr_pkg.sv =====
// Shared types, constants and the byte-wide CRC-16 step of the frame receiver.
package cfr_pkg;

  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h8408;
  localparam logic [7:0]  HEADER_RESET  = 8'hA5;
  localparam logic [7:0]  COMMAND_RESET = 8'h05;

  localparam int FIELD_FIRST = 2;
  localparam int FIELD_LAST  = 14;
  localparam int BODY_BYTES  = FIELD_LAST - FIELD_FIRST + 1;

  typedef enum logic {
    CFG_HEADER  = 1'b0,
    CFG_COMMAND = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
  } byte_word_t;

  typedef struct packed {
    logic        frame_ok;
    logic [15:0] length_field;
    logic [31:0] yaw_bits;
    logic [31:0] pitch_bits;
    logic [7:0]  mode_byte;
    logic [7:0]  side_byte;
    logic [7:0]  speed_mode_byte;
    logic [15:0] computed_crc;
  } frame_res_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/cfr_in_reg.sv =====
// Input register stage that holds one received byte word until the parser takes it.
module cfr_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [7:0]         rx_byte_i,
  input  logic               adv_i,
  output cfr_pkg::byte_word_t word_o
);
  import cfr_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       take;

  assign rx_ready_o = !valid_q || adv_i;
  assign take       = rx_valid_i && rx_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= rx_byte_i;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.data  = data_q;

endmodule

// ===== design/cfr_parser.sv =====
// Frame hunt, running CRC, field capture and result build for one byte per cycle while step_i is high.
module cfr_parser #(
  parameter int FRAME_BYTES = 17
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  logic [7:0]         header_i,
  input  logic [7:0]         command_i,
  output logic               last_o,
  output cfr_pkg::frame_res_t res_o
);
  import cfr_pkg::*;

  localparam int PW = $clog2(FRAME_BYTES);
  localparam logic [PW-1:0] POS_ONE  = PW'(1);
  localparam logic [PW-1:0] POS_TWO  = PW'(2);
  localparam logic [PW-1:0] CRC_END  = PW'(FRAME_BYTES - 2);
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_BYTES - 1);

  logic [PW-1:0] pos_q, pos_d;
  logic [15:0]   crc_q, crc_d;
  logic [15:0]   crc_step;
  logic          restart;
  logic [7:0]    body_q [BODY_BYTES];
  logic [7:0]    trailer_lo_q;

  assign restart  = (pos_q == '0) || ((pos_q == POS_ONE) && (byte_i != command_i));
  assign crc_step = crc16_step(restart ? CRC_INIT : crc_q, byte_i);

  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    priority if (pos_q == '0) begin
      if (byte_i == header_i) begin
        pos_d = POS_ONE;
        crc_d = crc_step;
      end else begin
        pos_d = '0;
        crc_d = CRC_INIT;
      end
    end else if (pos_q == POS_ONE) begin
      if (byte_i == command_i) begin
        pos_d = POS_TWO;
        crc_d = crc_step;
      end else if (byte_i == header_i) begin
        pos_d = POS_ONE;
        crc_d = crc_step;
      end else begin
        pos_d = '0;
        crc_d = CRC_INIT;
      end
    end else if (pos_q == LAST_POS) begin
      pos_d = '0;
      crc_d = CRC_INIT;
    end else begin
      pos_d = pos_q + PW'(1);
      if (pos_q < CRC_END) begin
        crc_d = crc_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CRC_INIT;
    end else if (step_i) begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && (pos_q == CRC_END)) begin
      trailer_lo_q <= byte_i;
    end
    for (int i = 0; i < BODY_BYTES; i++) begin
      if (step_i && (pos_q == PW'(i + FIELD_FIRST))) begin
        body_q[i] <= byte_i;
      end
    end
  end

  assign last_o = (pos_q == LAST_POS);

  assign res_o.frame_ok        = (crc_q == {byte_i, trailer_lo_q});
  assign res_o.length_field    = {body_q[1], body_q[0]};
  assign res_o.yaw_bits        = {body_q[5], body_q[4], body_q[3], body_q[2]};
  assign res_o.pitch_bits      = {body_q[9], body_q[8], body_q[7], body_q[6]};
  assign res_o.mode_byte       = body_q[10];
  assign res_o.side_byte       = body_q[11];
  assign res_o.speed_mode_byte = body_q[12];
  assign res_o.computed_crc    = crc_q;

endmodule

// ===== design/crc16_checked_frame_receiver.sv =====
// Top level of the CRC-16 checked frame receiver.
// Usage:
//   rx channel (rx_valid_i/rx_ready_o/rx_byte_i) carries one received byte per word.
//   res channel (res_valid_o/res_ready_i and field ports) carries one word per frame.
//   The block hunts for the header byte then the command byte, collects the
//   rest of the frame, and checks the CRC-16 (poly 0x8408, init 0xFFFF) over all
//   bytes but the last two against the trailer, low byte first.
//   Config: cfg_we_i writes cfg_wdata_i to header (index 0) or command (index 1).
// Timing:
//   One byte word is taken every cycle while the input register is not held; the
//   result of a frame goes through the input register, then the result register.
//   The CRC takes one byte-wide step per cycle in the parser while it advances.
// Reset:
//   Clears the hunt state, the CRC and both channel valids; header 0xA5,
//   command 0x05.
// Backpressure:
//   A result waits in the result register while res_ready_i is low; bytes that
//   do not end a frame keep flowing, and the final byte of the next frame holds
//   in the input register until the result register frees.
module crc16_checked_frame_receiver #(
  parameter int FRAME_BYTES = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic        frame_ok_o,
  output logic [15:0] length_field_o,
  output logic [31:0] yaw_bits_o,
  output logic [31:0] pitch_bits_o,
  output logic [7:0]  mode_byte_o,
  output logic [7:0]  side_byte_o,
  output logic [7:0]  speed_mode_byte_o,
  output logic [15:0] computed_crc_o
);
  import cfr_pkg::*;

  logic       [7:0] header_q;
  logic       [7:0] command_q;
  byte_word_t       word;
  logic             adv;
  logic             last;
  frame_res_t       res;
  frame_res_t       res_q;
  logic             res_valid_q, res_valid_d;
  logic             load;
  cfg_idx_e         cfg_idx;

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= HEADER_RESET;
      command_q <= COMMAND_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_HEADER:  header_q  <= cfg_wdata_i;
        CFG_COMMAND: command_q <= cfg_wdata_i;
        default:     header_q  <= header_q;
      endcase
    end
  end

  assign adv  = word.valid && (!last || !res_valid_q || res_ready_i);
  assign load = adv && last;

  cfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_ready_o (rx_ready_o),
    .rx_byte_i  (rx_byte_i),
    .adv_i      (adv),
    .word_o     (word)
  );

  cfr_parser #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv),
    .byte_i    (word.data),
    .header_i  (header_q),
    .command_i (command_q),
    .last_o    (last),
    .res_o     (res)
  );

  always_comb begin
    res_valid_d = res_valid_q;
    if (load) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res;
    end
  end

  assign res_valid_o       = res_valid_q;
  assign frame_ok_o        = res_q.frame_ok;
  assign length_field_o    = res_q.length_field;
  assign yaw_bits_o        = res_q.yaw_bits;
  assign pitch_bits_o      = res_q.pitch_bits;
  assign mode_byte_o       = res_q.mode_byte;
  assign side_byte_o       = res_q.side_byte;
  assign speed_mode_byte_o = res_q.speed_mode_byte;
  assign computed_crc_o    = res_q.computed_crc;

endmodule

// ===== design/cfr_checker.sv =====
// Port-level checker for the frame receiver and its bind to the top level.
`include "crc16_checked_frame_receiver_macros.svh"

module cfr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic rx_valid_i,
  input logic rx_ready_o,
  input logic res_valid_o,
  input logic res_ready_i
);

  `CFR_ASSERT_NEXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o, "result word dropped while stalled")

  `CFR_ASSERT_IMPL(a_rx_open, !res_valid_o || res_ready_i, rx_ready_o, "input stalled with result path free")

  `CFR_ASSERT_IMPL(a_res_cause, $rose(res_valid_o), $past(rx_valid_i && rx_ready_o, 2), "result word without a byte word two cycles before")

endmodule

bind crc16_checked_frame_receiver cfr_checker u_cfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rx_valid_i  (rx_valid_i),
  .rx_ready_o  (rx_ready_o),
  .res_valid_o (res_valid_o),
  .res_ready_i (res_ready_i)
);
